// ===== rtl/gscr_pkg.sv =====
// ----------------------------------------------------------------------------
// gscr_pkg
// Shared types, constants and helpers of the glyph span cache.
// ----------------------------------------------------------------------------
package gscr_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam logic [3:0] LAST_ROW = 4'd15;
  localparam logic [5:0] GLYPH_ROWS = 6'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_VSCAN,
    ST_BUILD_INIT,
    ST_RUN,
    ST_MRD,
    ST_MCHK,
    ST_APPEND,
    ST_EMIT_RD,
    ST_EMIT_PUSH,
    ST_FB_INIT,
    ST_FB_RUN
  } front_state_t;

  typedef struct packed {
    logic [3:0] rows_m1;
    logic [2:0] run_m1;
    logic [2:0] start;
    logic [3:0] row;
  } span_t;

  typedef struct packed {
    logic [2:0] start;
    logic [3:0] len;
    logic [7:0] rest;
  } run_info_t;

  typedef struct packed {
    logic [2:0]  col;
    logic [3:0]  row;
    logic [3:0]  run;
    logic [4:0]  rows;
    logic        last;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] ink;
    logic [7:0]  sc;
    logic [15:0] cw;
  } desc_t;

  function automatic logic [7:0] row_bits(input logic [63:0] top, input logic [63:0] bot,
                                          input logic [3:0] r);
    logic [63:0] w;
    w = r[3] ? bot : top;
    return w[8*(3'd7 - r[2:0]) +: 8];
  endfunction

  function automatic run_info_t first_run(input logic [7:0] bits);
    run_info_t ri;
    logic found;
    logic inrun;
    ri = '0;
    found = 1'b0;
    inrun = 1'b0;
    ri.rest = bits;
    for (int c = 0; c < 8; c++) begin
      if (bits[7-c]) begin
        if (!found) begin
          found = 1'b1;
          inrun = 1'b1;
          ri.start = 3'(c);
        end
        if (inrun) begin
          ri.len = ri.len + 4'd1;
          ri.rest[7-c] = 1'b0;
        end
      end else begin
        inrun = 1'b0;
      end
    end
    return ri;
  endfunction

endpackage

// ===== rtl/gscr_fifo.sv =====
// ----------------------------------------------------------------------------
// gscr_fifo
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module gscr_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  gscr_pkg::desc_t wdata,
  output logic           full,
  input  logic           rd,
  output gscr_pkg::desc_t rdata,
  output logic           empty
);
  import gscr_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  desc_t           store [FIFO_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     count;

  assign full  = (count == (PW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = store[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      store[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/gscr_front.sv =====
// ----------------------------------------------------------------------------
// gscr_front
// Request intake, cache lookup, victim choice, span build, span readout and row-run fallback.
// ----------------------------------------------------------------------------
module gscr_front #(
  parameter int CACHE_SLOTS    = 16,
  parameter int SPANS_PER_SLOT = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            func,
  input  logic [7:0]      char_code,
  input  logic [63:0]     glyph_rows_top,
  input  logic [63:0]     glyph_rows_bottom,
  input  logic [15:0]     origin_x,
  input  logic [15:0]     origin_y,
  input  logic [31:0]     ink_color,
  input  logic [7:0]      scale,
  input  logic [15:0]     cell_width,
  output logic            q_push,
  output gscr_pkg::desc_t q_desc,
  input  logic            q_full
);
  import gscr_pkg::*;

  localparam int SW    = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int IW    = (SPANS_PER_SLOT > 1) ? $clog2(SPANS_PER_SLOT) : 1;
  localparam int CW    = $clog2(SPANS_PER_SLOT + 1);
  localparam int DEPTH = CACHE_SLOTS * SPANS_PER_SLOT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  front_state_t state, state_next;

  logic [7:0]    r_char;
  logic [63:0]   r_top;
  logic [63:0]   r_bot;
  logic [15:0]   r_x;
  logic [15:0]   r_y;
  logic [31:0]   r_ink;
  logic [7:0]    r_sc;
  logic [15:0]   r_cw;

  logic [7:0]    slot_char  [CACHE_SLOTS];
  logic [7:0]    slot_scale [CACHE_SLOTS];
  logic          slot_valid [CACHE_SLOTS];
  logic [CW-1:0] slot_cnt   [CACHE_SLOTS];
  logic [7:0]    slot_age   [CACHE_SLOTS];
  logic [7:0]    age_clock;
  logic          cache_live;

  logic [SW-1:0] slot;
  logic [SW-1:0] vscan;
  logic [7:0]    vmin;
  logic [IW-1:0] mscan;
  logic [CW-1:0] bcount;
  logic [CW-1:0] ecnt;
  logic [CW-1:0] ei;
  logic [3:0]    row;
  logic [7:0]    cur_bits;
  logic [2:0]    run_st;
  logic [3:0]    run_n;

  span_t         span_mem [DEPTH];
  span_t         rdata;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic          mem_re;
  span_t         mem_wdata;

  logic          hit;
  logic [SW-1:0] hit_idx;
  logic [AW-1:0] base;
  run_info_t     fr;
  logic [7:0]    rb0;
  logic [7:0]    rb_next;
  logic [15:0]   rownz;
  logic          later_nz;
  logic [4:0]    sp_end;
  logic          m_match;
  logic          m_stop;
  logic          accept;

  assign full   = (state != ST_IDLE);
  assign accept = push && !full;
  assign base   = AW'(slot) * AW'(SPANS_PER_SLOT);
  assign fr     = first_run(cur_bits);
  assign rb0    = row_bits(r_top, r_bot, 4'd0);
  assign rb_next = row_bits(r_top, r_bot, row + 4'd1);
  assign later_nz = |((rownz >> row) >> 1);
  assign sp_end  = 5'(rdata.row) + 5'(rdata.rows_m1) + 5'd1;
  assign m_match = (rdata.start == run_st) && (rdata.run_m1 == 3'(run_n - 4'd1)) &&
                   (sp_end == 5'(row));
  assign m_stop  = (sp_end < 5'(row)) || (mscan == '0);

  always_comb begin
    for (int r = 0; r < 16; r++) begin
      rownz[r] = |row_bits(r_top, r_bot, 4'(r));
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_char[i] == r_char && slot_scale[i] == r_sc) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
    end
    hit = hit && cache_live;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !func) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (hit) state_next = ST_EMIT_RD;
        else if (!cache_live || CACHE_SLOTS == 1) state_next = ST_BUILD_INIT;
        else state_next = ST_VSCAN;
      end
      ST_VSCAN: begin
        if (vscan == SW'(CACHE_SLOTS - 1)) state_next = ST_BUILD_INIT;
      end
      ST_BUILD_INIT: state_next = ST_RUN;
      ST_RUN: begin
        if (cur_bits == '0) begin
          if (row == LAST_ROW) state_next = ST_EMIT_RD;
        end else if (bcount == '0) begin
          state_next = ST_APPEND;
        end else begin
          state_next = ST_MRD;
        end
      end
      ST_MRD: state_next = ST_MCHK;
      ST_MCHK: begin
        if (m_match) state_next = ST_RUN;
        else if (m_stop) state_next = ST_APPEND;
        else state_next = ST_MRD;
      end
      ST_APPEND: begin
        if (bcount >= CW'(SPANS_PER_SLOT)) state_next = ST_FB_INIT;
        else state_next = ST_RUN;
      end
      ST_EMIT_RD: begin
        if (ei == ecnt) state_next = ST_IDLE;
        else state_next = ST_EMIT_PUSH;
      end
      ST_EMIT_PUSH: begin
        if (!q_full) state_next = ST_EMIT_RD;
      end
      ST_FB_INIT: state_next = ST_FB_RUN;
      ST_FB_RUN: begin
        if (cur_bits == '0 && row == LAST_ROW) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_addr  = base;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = rdata;
    q_push    = 1'b0;
    q_desc    = '0;
    q_desc.x   = r_x;
    q_desc.y   = r_y;
    q_desc.ink = r_ink;
    q_desc.sc  = r_sc;
    q_desc.cw  = r_cw;
    unique case (state)
      ST_MRD: begin
        mem_re   = 1'b1;
        mem_addr = base + AW'(mscan);
      end
      ST_MCHK: begin
        mem_addr = base + AW'(mscan);
        mem_we   = m_match;
        mem_wdata.rows_m1 = rdata.rows_m1 + 4'd1;
      end
      ST_APPEND: begin
        mem_addr  = base + AW'(bcount);
        mem_we    = (bcount < CW'(SPANS_PER_SLOT));
        mem_wdata.rows_m1 = 4'd0;
        mem_wdata.run_m1  = 3'(run_n - 4'd1);
        mem_wdata.start   = run_st;
        mem_wdata.row     = row;
      end
      ST_EMIT_RD: begin
        mem_addr = base + AW'(ei);
        mem_re   = (ei != ecnt);
      end
      ST_EMIT_PUSH: begin
        q_push      = !q_full;
        q_desc.col  = rdata.start;
        q_desc.row  = rdata.row;
        q_desc.run  = 4'(rdata.run_m1) + 4'd1;
        q_desc.rows = 5'(rdata.rows_m1) + 5'd1;
        q_desc.last = (ei + CW'(1) == ecnt);
      end
      ST_FB_RUN: begin
        q_push      = (cur_bits != '0) && !q_full;
        q_desc.col  = fr.start;
        q_desc.row  = row;
        q_desc.run  = fr.len;
        q_desc.rows = 5'd1;
        q_desc.last = (fr.rest == '0) && !later_nz;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      span_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= span_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      r_char <= char_code;
      r_top  <= glyph_rows_top;
      r_bot  <= glyph_rows_bottom;
      r_x    <= origin_x;
      r_y    <= origin_y;
      r_ink  <= ink_color;
      r_sc   <= scale;
      r_cw   <= cell_width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cache_live <= 1'b0;
      age_clock  <= '0;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_cnt[i]   <= '0;
        slot_age[i]   <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (accept && func) cache_live <= 1'b0;
        end
        ST_LOOKUP: begin
          if (hit) begin
            age_clock         <= age_clock + 8'd1;
            slot_age[hit_idx] <= age_clock + 8'd1;
            slot              <= hit_idx;
            ecnt              <= slot_cnt[hit_idx];
            ei                <= '0;
          end else if (!cache_live) begin
            for (int i = 0; i < CACHE_SLOTS; i++) begin
              slot_valid[i] <= 1'b0;
              slot_cnt[i]   <= '0;
              slot_age[i]   <= '0;
            end
            cache_live <= 1'b1;
            age_clock  <= '0;
            slot       <= '0;
          end else begin
            slot  <= '0;
            vmin  <= slot_age[0];
            vscan <= SW'(1);
          end
        end
        ST_VSCAN: begin
          if (slot_age[vscan] < vmin) begin
            slot <= vscan;
            vmin <= slot_age[vscan];
          end
          vscan <= vscan + SW'(1);
        end
        ST_BUILD_INIT: begin
          slot_char[slot]  <= r_char;
          slot_scale[slot] <= r_sc;
          slot_valid[slot] <= 1'b0;
          slot_cnt[slot]   <= '0;
          bcount           <= '0;
          row              <= '0;
          cur_bits         <= rb0;
        end
        ST_RUN: begin
          if (cur_bits == '0) begin
            if (row == LAST_ROW) begin
              slot_valid[slot] <= 1'b1;
              slot_cnt[slot]   <= bcount;
              age_clock        <= age_clock + 8'd1;
              slot_age[slot]   <= age_clock + 8'd1;
              ecnt             <= bcount;
              ei               <= '0;
            end else begin
              row      <= row + 4'd1;
              cur_bits <= rb_next;
            end
          end else begin
            run_st   <= fr.start;
            run_n    <= fr.len;
            cur_bits <= fr.rest;
            mscan    <= IW'(bcount - CW'(1));
          end
        end
        ST_MCHK: begin
          if (!m_match && !m_stop) mscan <= mscan - IW'(1);
        end
        ST_APPEND: begin
          if (bcount < CW'(SPANS_PER_SLOT)) bcount <= bcount + CW'(1);
        end
        ST_EMIT_PUSH: begin
          if (!q_full) ei <= ei + CW'(1);
        end
        ST_FB_INIT: begin
          row      <= '0;
          cur_bits <= rb0;
        end
        ST_FB_RUN: begin
          if (cur_bits == '0) begin
            if (row != LAST_ROW) begin
              row      <= row + 4'd1;
              cur_bits <= rb_next;
            end
          end else if (!q_full) begin
            cur_bits <= fr.rest;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/gscr_back.sv =====
// ----------------------------------------------------------------------------
// gscr_back
// Rectangle generation from span descriptors, with the result register.
// ----------------------------------------------------------------------------
module gscr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  gscr_pkg::desc_t q_desc,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic [31:0]     rect_x,
  output logic [31:0]     rect_y,
  output logic [10:0]     rect_w,
  output logic [11:0]     rect_h,
  output logic [31:0]     rect_color,
  output logic            shadow_first,
  output logic            last
);
  import gscr_pkg::*;

  logic        ovalid;
  logic [10:0] cx;
  logic [11:0] cy;
  logic [10:0] w;
  logic [11:0] h;
  logic        sh;
  logic        ld;

  assign cx = 11'(q_desc.col) * 11'(q_desc.sc);
  assign cy = 12'(q_desc.row) * 12'(q_desc.sc);
  assign w  = 11'(q_desc.run) * 11'(q_desc.sc);
  assign h  = 12'(q_desc.rows) * 12'(q_desc.sc);
  assign sh = (q_desc.sc == 8'd1) &&
              (17'(q_desc.col) + 17'(q_desc.run) + 17'd1 <= 17'(q_desc.cw)) &&
              (6'(q_desc.row) + 6'(q_desc.rows) + 6'd1 <= GLYPH_ROWS);

  assign ld    = !q_empty && (!ovalid || pop);
  assign q_pop = ld;
  assign empty = !ovalid;

  always_ff @(posedge clk) begin
    if (ld) begin
      rect_x       <= 32'(q_desc.x) + 32'(cx);
      rect_y       <= 32'(q_desc.y) + 32'(cy);
      rect_w       <= w;
      rect_h       <= h;
      rect_color   <= q_desc.ink;
      shadow_first <= sh;
      last         <= q_desc.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (ld) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

endmodule

// ===== rtl/glyph_span_cache_rect_gen_top.sv =====
// ----------------------------------------------------------------------------
// glyph_span_cache_rect_gen_top
// Glyph draw engine with a span cache, emitting scaled fill rectangles.
// ----------------------------------------------------------------------------
// Input channel: push/full. A draw request (func 0) or a cache invalidate
// (func 1) is taken when push is high and full is low. Full stays high while
// the front works on a request, so one request is in the front at a time.
// Result channel: empty/pop. The oldest rectangle sits on the rect ports while
// empty is low and leaves when pop is high; last marks a request's final one.
// An invalidate only marks the cache stale; the next draw clears it. A hit reads
// its spans back from the span memory. A miss scans the slots for the oldest
// victim, then walks the glyph rows and merges each run into the slot's spans
// over the single-port span memory; a slot whose spans overflow is dropped and
// its runs are sent row by row instead.
// Reset clears the cache state and both queues; no sweep is needed.
// A stalled receiver fills the output register and the 4-entry descriptor
// queue, after which the front holds until room frees; nothing is dropped.
// ----------------------------------------------------------------------------
module glyph_span_cache_rect_gen_top #(
  parameter int CACHE_SLOTS    = 16,
  parameter int SPANS_PER_SLOT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [7:0]  char_code,
  input  logic [63:0] glyph_rows_top,
  input  logic [63:0] glyph_rows_bottom,
  input  logic [15:0] origin_x,
  input  logic [15:0] origin_y,
  input  logic [31:0] ink_color,
  input  logic [7:0]  scale,
  input  logic [15:0] cell_width,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] rect_x,
  output logic [31:0] rect_y,
  output logic [10:0] rect_w,
  output logic [11:0] rect_h,
  output logic [31:0] rect_color,
  output logic        shadow_first,
  output logic        last
);
  import gscr_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  desc_t q_wdata;
  desc_t q_rdata;

  gscr_front #(
    .CACHE_SLOTS   (CACHE_SLOTS),
    .SPANS_PER_SLOT(SPANS_PER_SLOT)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .func             (func),
    .char_code        (char_code),
    .glyph_rows_top   (glyph_rows_top),
    .glyph_rows_bottom(glyph_rows_bottom),
    .origin_x         (origin_x),
    .origin_y         (origin_y),
    .ink_color        (ink_color),
    .scale            (scale),
    .cell_width       (cell_width),
    .q_push           (q_push),
    .q_desc           (q_wdata),
    .q_full           (q_full)
  );

  gscr_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .rd   (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  gscr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_desc      (q_rdata),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_w      (rect_w),
    .rect_h      (rect_h),
    .rect_color  (rect_color),
    .shadow_first(shadow_first),
    .last        (last)
  );

endmodule

// ===== test/glyph_span_cache_rect_gen_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_span_cache_rect_gen_top_tb
// Self-checking bench for the glyph span cache rectangle generator. A directed
// table covers key cases (empty glyph, field extremes, invalidate, span overflow,
// scale zero, eviction ties), then random requests drawn from a small key pool
// exercise hits and evictions. Every rectangle is compared field by field
// against an in-bench cache predictor or a fixed expected value, under several
// sender and receiver idle mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module glyph_span_cache_rect_gen_top_tb;
  import gscr_pkg::*;

  localparam int NSLOTS = 16;
  localparam int NSPANS = 16;
  localparam logic FN_DRAW = 1'b0;
  localparam logic FN_INVAL = 1'b1;
  localparam int RAND_ITEMS = 330;
  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [10:0] w;
    logic [11:0] h;
    logic [31:0] color;
    logic        shadow;
    logic        fin;
  } rect_t;

  typedef struct {
    logic        fn;
    logic [7:0]  ch;
    logic [63:0] top;
    logic [63:0] bot;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] ink;
    logic [7:0]  sc;
    logic [15:0] cw;
    int          known_n;
    rect_t       known;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        func = FN_DRAW;
  logic [7:0]  char_code = '0;
  logic [63:0] glyph_rows_top = '0;
  logic [63:0] glyph_rows_bottom = '0;
  logic [15:0] origin_x = '0;
  logic [15:0] origin_y = '0;
  logic [31:0] ink_color = '0;
  logic [7:0]  scale = 8'd1;
  logic [15:0] cell_width = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] rect_x;
  logic [31:0] rect_y;
  logic [10:0] rect_w;
  logic [11:0] rect_h;
  logic [31:0] rect_color;
  logic        shadow_first;
  logic        last;

  glyph_span_cache_rect_gen_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] key_char[NSLOTS];
  logic [7:0] key_scale[NSLOTS];
  logic       slot_ok[NSLOTS];
  int         slot_spans[NSLOTS];
  span_t      spans[NSLOTS][NSPANS];
  logic [7:0] slot_stamp[NSLOTS];
  logic [7:0] stamp_clock;
  logic       cache_on;

  rect_t rect_due[$];
  req_t  dir_tab[$];
  int    errors = 0;
  int    cycles = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  logic  hold_pop = 1'b0;
  logic  dir_done = 1'b0;

  function automatic logic [7:0] glyph_row(logic [63:0] top, logic [63:0] bot, int r);
    logic [63:0] w;
    w = (r < 8) ? top : bot;
    return w[63 - 8 * (r % 8) -: 8];
  endfunction

  function automatic void add_rect(req_t q, int col, int row, int run, int rows);
    rect_t o;
    logic [31:0] sc, px, py, rw, rh;
    sc = q.sc;
    px = q.x + col * sc;
    py = q.y + row * sc;
    rw = run * sc;
    rh = rows * sc;
    o.x = px;
    o.y = py;
    o.w = rw[10:0];
    o.h = rh[11:0];
    o.color = q.ink;
    o.shadow = (sc == 1) && (px + 1 + rw <= q.x + q.cw) && (py + 1 + rh <= q.y + 16 * sc);
    o.fin = 1'b0;
    rect_due.push_back(o);
  endfunction

  function automatic void add_row_runs(req_t q, int row, output int st[4], output int rn[4],
                                       output int m);
    logic [7:0] b;
    int c, s;
    b = glyph_row(q.top, q.bot, row);
    m = 0;
    c = 0;
    while (c < 8) begin
      while (c < 8 && !b[7 - c]) c++;
      if (c < 8) begin
        s = c;
        while (c < 8 && b[7 - c]) c++;
        st[m] = s;
        rn[m] = c - s;
        m++;
      end
    end
  endfunction

  function automatic logic fold_into(int v, int row, int start, int run);
    int e;
    for (int i = slot_spans[v] - 1; i >= 0; i--) begin
      e = spans[v][i].row + spans[v][i].rows_m1 + 1;
      if (spans[v][i].start == start && spans[v][i].run_m1 + 1 == run && e == row) begin
        spans[v][i].rows_m1 = spans[v][i].rows_m1 + 1;
        return 1'b1;
      end
      if (e < row) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic logic build_slot(int v, req_t q);
    int st[4], rn[4], m;
    key_char[v] = q.ch;
    key_scale[v] = q.sc;
    slot_spans[v] = 0;
    slot_ok[v] = 1'b0;
    for (int r = 0; r < 16; r++) begin
      add_row_runs(q, r, st, rn, m);
      for (int k = 0; k < m; k++) begin
        if (!fold_into(v, r, st[k], rn[k])) begin
          if (slot_spans[v] >= NSPANS) begin
            slot_spans[v] = 0;
            return 1'b0;
          end
          spans[v][slot_spans[v]] = '{rows_m1: 4'd0, run_m1: 3'(rn[k] - 1),
                                      start: 3'(st[k]), row: 4'(r)};
          slot_spans[v]++;
        end
      end
    end
    slot_ok[v] = 1'b1;
    stamp_clock++;
    slot_stamp[v] = stamp_clock;
    return 1'b1;
  endfunction

  function automatic void draw_glyph_predict(req_t q);
    int hit, v, n0, st[4], rn[4], m;
    span_t p;
    n0 = rect_due.size();
    hit = -1;
    if (q.fn == FN_INVAL) begin
      cache_on = 1'b0;
      return;
    end
    if (cache_on)
      for (int i = 0; i < NSLOTS; i++)
        if (hit < 0 && slot_ok[i] && key_char[i] == q.ch && key_scale[i] == q.sc) begin
          stamp_clock++;
          slot_stamp[i] = stamp_clock;
          hit = i;
        end
    if (hit < 0) begin
      v = 0;
      if (!cache_on) begin
        for (int i = 0; i < NSLOTS; i++) begin
          slot_ok[i] = 1'b0;
          slot_spans[i] = 0;
          slot_stamp[i] = '0;
        end
        cache_on = 1'b1;
        stamp_clock = '0;
      end else begin
        for (int i = 1; i < NSLOTS; i++)
          if (slot_stamp[i] < slot_stamp[v]) v = i;
      end
      if (build_slot(v, q)) hit = v;
    end
    if (hit >= 0) begin
      for (int i = 0; i < slot_spans[hit]; i++) begin
        p = spans[hit][i];
        add_rect(q, p.start, p.row, p.run_m1 + 1, p.rows_m1 + 1);
      end
    end else begin
      for (int r = 0; r < 16; r++) begin
        add_row_runs(q, r, st, rn, m);
        for (int k = 0; k < m; k++) add_rect(q, st[k], r, rn[k], 1);
      end
    end
    if (rect_due.size() > n0) rect_due[$].fin = 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send(req_t q);
    int n0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    func <= q.fn;
    char_code <= q.ch;
    glyph_rows_top <= q.top;
    glyph_rows_bottom <= q.bot;
    origin_x <= q.x;
    origin_y <= q.y;
    ink_color <= q.ink;
    scale <= q.sc;
    cell_width <= q.cw;
    @(posedge clk);
    while (full) @(posedge clk);
    n0 = rect_due.size();
    draw_glyph_predict(q);
    if (q.known_n >= 0) begin
      while (rect_due.size() > n0) void'(rect_due.pop_back());
      if (q.known_n > 0) rect_due.push_back(q.known);
    end
  endtask

  function automatic req_t mk(logic fn, logic [7:0] ch, logic [63:0] top, logic [63:0] bot,
                              logic [15:0] x, logic [15:0] y, logic [7:0] sc,
                              logic [15:0] cw);
    req_t q;
    q.fn = fn;
    q.ch = ch;
    q.top = top;
    q.bot = bot;
    q.x = x;
    q.y = y;
    q.ink = {$urandom};
    q.sc = sc;
    q.cw = cw;
    q.known_n = -1;
    q.known = '{default: '0};
    return q;
  endfunction

  function automatic logic [63:0] rand_glyph(int style);
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case (style)
      0: return a & b;
      1: return a | b;
      2: return {8{a[7:0]}};
      3: return {4{a[15:0]}};
      4: return 64'hAA55_AA55_AA55_AA55;
      default: return a;
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    rect_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (rect_due.size() == 0) begin
          report("unexpected rect_x", rect_x, 32'h0);
        end else begin
          e = rect_due.pop_front();
          if (rect_x !== e.x) report("rect_x", rect_x, e.x);
          if (rect_y !== e.y) report("rect_y", rect_y, e.y);
          if (rect_w !== e.w) report("rect_w", rect_w, e.w);
          if (rect_h !== e.h) report("rect_h", rect_h, e.h);
          if (rect_color !== e.color) report("rect_color", rect_color, e.color);
          if (shadow_first !== e.shadow) report("shadow_first", shadow_first, e.shadow);
          if (last !== e.fin) report("last", last, e.fin);
        end
      end
      pop <= !hold_pop && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    wait (dir_done);
    @(posedge clk);
    hold_pop <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_pop <= 1'b0;
  end

  initial begin
    req_t q;
    int sty;
    cache_on = 1'b0;
    stamp_clock = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      slot_ok[i] = 1'b0;
      slot_spans[i] = 0;
      slot_stamp[i] = '0;
    end

    q = mk(FN_DRAW, 8'd0, '0, '0, 16'd5, 16'd5, 8'd1, 16'd8);
    q.known_n = 0;
    dir_tab.push_back(q);
    q = mk(FN_DRAW, 8'd1, 64'h8000_0000_0000_0000, '0, 16'd0, 16'd0, 8'd1, 16'd8);
    q.known_n = 1;
    q.known = '{32'd0, 32'd0, 11'd1, 12'd1, q.ink, 1'b1, 1'b1};
    dir_tab.push_back(q);
    q = mk(FN_DRAW, 8'd255, '1, '1, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF);
    q.known_n = 1;
    q.known = '{32'hFFFF, 32'hFFFF, 11'd2040, 12'd4080, q.ink, 1'b0, 1'b1};
    dir_tab.push_back(q);
    q = mk(FN_INVAL, 8'd255, '1, '1, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF);
    q.known_n = 0;
    dir_tab.push_back(q);
    dir_tab.push_back(mk(FN_DRAW, 8'd3, 64'hAA55_AA55_AA55_AA55, 64'hAA55_AA55_AA55_AA55,
                         16'd100, 16'd200, 8'd1, 16'd9));
    dir_tab.push_back(mk(FN_DRAW, 8'd1, '1, '0, 16'd7, 16'd9, 8'd1, 16'd3));
    dir_tab.push_back(mk(FN_DRAW, 8'd4, 64'h3C42_8181_FF81_8181, 64'h8181_8181_0000_0000,
                         16'd1, 16'd1, 8'd0, 16'd8));
    for (int i = 0; i < 17; i++)
      dir_tab.push_back(mk(FN_DRAW, 8'(10 + i), rand_glyph(i % 4), rand_glyph(i % 3),
                           16'($urandom), 16'($urandom), 8'd2, 16'($urandom)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) send(dir_tab[i]);
    dir_done = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 75 : (ph == 3) ? 10 : 0;
      recv_stall_pct <= (ph == 2) ? 75 : (ph == 3) ? 10 : 0;
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        sty = $urandom_range(0, 19);
        q = mk(FN_DRAW, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23)),
               rand_glyph(sty % 6), rand_glyph((sty + 1) % 6), 16'($urandom), 16'($urandom),
               ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3)),
               ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 12)) : 16'($urandom));
        if ($urandom_range(0, 24) == 0) q.fn = FN_INVAL;
        if (sty == 19) q.top = '0;
        send(q);
      end
    end
    push <= 1'b0;
    recv_stall_pct <= 0;

    while (rect_due.size() > 0 || hold_pop) @(posedge clk);
    repeat (400) @(posedge clk);
    if (rect_due.size() > 0) begin
      report("rectangles missing", 32'(rect_due.size()), 32'h0);
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
